[rtl/dtt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types, constants and helpers for the divider and timer peripheral.
// ----------------------------------------------------------------------------
package dtt_pkg;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdRead  = 2'd1,
    CmdWrite = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegDiv  = 2'd0,
    RegTima = 2'd1,
    RegTma  = 2'd2,
    RegTac  = 2'd3
  } reg_e;

  localparam logic [2:0] CtrlEnable   = 3'h4;
  localparam logic [2:0] CtrlMask     = 3'h7;
  localparam logic [4:0] CtrlReadOnes = 5'h1F;
  localparam logic [2:0] ReloadTicks  = 3'd4;
  localparam logic [2:0] WindowTicks  = 3'd4;

  // Level of the divider bit selected by control, gated by the enable bit.
  function automatic logic tap_level(input logic [15:0] div, input logic [2:0] ctrl);
    logic bit_v;
    unique case (ctrl[1:0])
      2'd0:    bit_v = div[9];
      2'd1:    bit_v = div[3];
      2'd2:    bit_v = div[5];
      default: bit_v = div[7];
    endcase
    return ((ctrl & CtrlEnable) != 3'h0) && bit_v;
  endfunction

endpackage
`default_nettype wire

[rtl/div_tima_timer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// div_tima_timer_top
// Divider and timer peripheral: one tick, read, write or no-op per transaction.
// ----------------------------------------------------------------------------
// Each accepted transaction updates the divider, counter, modulo and control
// state in the cycle it is accepted, and its result (read byte and interrupt
// pulse) appears in the output register on the next cycle. One transaction
// per cycle is sustained while out_ready_i stays high; the single output
// register lets a new transaction in while the previous result is taken in
// the same cycle. A counter overflow reloads the counter from modulo four
// ticks later and raises timer_irq_o on the result of that tick.
module div_tima_timer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [1:0]  reg_select_i,
  input  wire logic [7:0]  write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic             timer_irq_o
);
  import dtt_pkg::*;

  logic [15:0] div_q, div_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  mod_q, mod_d;
  logic [2:0]  ctrl_q, ctrl_d;
  logic        pend_q, pend_d;
  logic [2:0]  wait_q, wait_d;
  logic [2:0]  win_q, win_d;
  logic        out_valid_q;
  logic [7:0]  rdata_q, rdata_d;
  logic        irq_q, irq_d;
  logic        in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign timer_irq_o = irq_q;

  always_comb begin
    logic [15:0] div_inc;
    logic [2:0]  wait_dec;
    logic        cnt_tick;
    logic [7:0]  cnt_inc;
    div_d    = div_q;
    cnt_d    = cnt_q;
    mod_d    = mod_q;
    ctrl_d   = ctrl_q;
    pend_d   = pend_q;
    wait_d   = wait_q;
    win_d    = win_q;
    rdata_d  = 8'h00;
    irq_d    = 1'b0;
    cnt_tick = 1'b0;
    div_inc  = div_q + 16'd1;
    wait_dec = (wait_q != 3'd0) ? wait_q - 3'd1 : 3'd0;
    unique case (command_i)
      CmdTick: begin
        if (win_q != 3'd0) begin
          win_d = win_q - 3'd1;
        end
        if (pend_q) begin
          wait_d = wait_dec;
          if (wait_dec == 3'd0) begin
            cnt_d  = mod_q;
            pend_d = 1'b0;
            win_d  = WindowTicks;
            irq_d  = 1'b1;
          end
        end
        div_d    = div_inc;
        cnt_tick = tap_level(div_q, ctrl_q) && !tap_level(div_inc, ctrl_q);
      end
      CmdRead: begin
        unique case (reg_select_i)
          RegDiv:  rdata_d = div_q[15:8];
          RegTima: rdata_d = cnt_q;
          RegTma:  rdata_d = mod_q;
          default: rdata_d = {CtrlReadOnes, ctrl_q};
        endcase
      end
      CmdWrite: begin
        unique case (reg_select_i)
          RegDiv: begin
            div_d    = 16'h0000;
            cnt_tick = tap_level(div_q, ctrl_q);
          end
          RegTima: begin
            if (win_q == 3'd0) begin
              pend_d = 1'b0;
              cnt_d  = write_data_i;
            end
          end
          RegTma: begin
            mod_d = write_data_i;
            if (win_q != 3'd0) begin
              cnt_d = write_data_i;
            end
          end
          default: begin
            ctrl_d   = write_data_i[2:0] & CtrlMask;
            cnt_tick = tap_level(div_q, ctrl_q) && !tap_level(div_q, ctrl_d);
          end
        endcase
      end
      default: begin
      end
    endcase
    cnt_inc = cnt_d + 8'd1;
    if (cnt_tick) begin
      cnt_d = cnt_inc;
      if (cnt_inc == 8'h00) begin
        pend_d = 1'b1;
        wait_d = ReloadTicks;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= 16'h0000;
      cnt_q  <= 8'h00;
      mod_q  <= 8'h00;
      ctrl_q <= 3'h0;
      pend_q <= 1'b0;
      wait_q <= 3'd0;
      win_q  <= 3'd0;
    end else if (in_fire) begin
      div_q  <= div_d;
      cnt_q  <= cnt_d;
      mod_q  <= mod_d;
      ctrl_q <= ctrl_d;
      pend_q <= pend_d;
      wait_q <= wait_d;
      win_q  <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

endmodule
`default_nettype wire

[rtl/dtt_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dtt_checker
// Port-level checks for the divider and timer peripheral.
// ----------------------------------------------------------------------------
module dtt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [1:0] command_i,
  input wire logic [1:0] reg_select_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] read_data_o,
  input wire logic       timer_irq_o
);
  import dtt_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(read_data_o) && $stable(timer_irq_o))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_ctrl_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && command_i == CmdRead && reg_select_i == RegTac |=>
      out_valid_o && read_data_o[7:3] == CtrlReadOnes)
    else $error("control read lost its fixed ones");

  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && command_i != CmdRead |=> out_valid_o && read_data_o == 8'h00)
    else $error("read data nonzero on a non-read transaction");

  a_irq_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && command_i != CmdTick |=> out_valid_o && !timer_irq_o)
    else $error("interrupt on a non-tick transaction");

endmodule

bind div_tima_timer_top dtt_checker u_dtt_checker (.*);
`default_nettype wire
